### hw/rtl/ffba_pkg.sv
`timescale 1ns / 1ps
// ffba_pkg: shared constants for the first-fit block allocator.
// Field widths, request modes and status codes. No dependencies.
package ffba_pkg;

	// Default sizing of the owner map
	localparam int POOL_CELLS_DEF = 16;
	localparam int ID_BITS_DEF    = 15;

	// Payload field widths
	localparam int MODE_W   = 1;
	localparam int COUNT_W  = 5;
	localparam int SIZE_W   = 5;
	localparam int POS_W    = 4;
	localparam int STATUS_W = 3;
	localparam int START_W  = 4;
	localparam int OUT_ID_W = 15;
	localparam int PROD_W   = COUNT_W + SIZE_W;

	// Request modes
	localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
	localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NULL_PTR     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_START    = 3'd4;

endpackage

### hw/rtl/ffba_req_if.sv
`timescale 1ns / 1ps
// ffba_req_if: request channel (valid/ready plus request fields).
// Depends on ffba_pkg for field widths.
interface ffba_req_if;
	import ffba_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [MODE_W-1:0]    mode;
	logic [COUNT_W-1:0]   element_count;
	logic [SIZE_W-1:0]    element_size;
	logic                 pointer_valid;
	logic [POS_W-1:0]     position;

	modport source (
		output valid, mode, element_count, element_size, pointer_valid, position,
		input  ready
	);
	modport sink (
		input  valid, mode, element_count, element_size, pointer_valid, position,
		output ready
	);
endinterface

### hw/rtl/ffba_rsp_if.sv
`timescale 1ns / 1ps
// ffba_rsp_if: result channel (valid/ready plus result fields).
// Depends on ffba_pkg for field widths.
interface ffba_rsp_if;
	import ffba_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [START_W-1:0]   block_start;
	logic [OUT_ID_W-1:0]  block_id;

	modport source (
		output valid, status, block_start, block_id,
		input  ready
	);
	modport sink (
		input  valid, status, block_start, block_id,
		output ready
	);
endinterface

### hw/rtl/ffba_ram.sv
`timescale 1ns / 1ps
// ffba_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### hw/rtl/first_fit_block_allocator.sv
`timescale 1ns / 1ps
// Allocate: a first-fit scan of the owner map, then the found run is stamped with a new id.
//   Free: read the cell at position, check the cell before for block start (not at cell
//   0), then clear the run. Decode rejects go straight to the result; already free is found
//   after the map read, not block start after the check of the cell before. One request at
//   a time: req.ready is high only in idle, after the last result is in the output register.
// Reset: arst_n clears control state, then a sweep writes zero to every owner-map cell
//   with req.ready low; next id restarts at 1.
module first_fit_block_allocator #(
	parameter int POOL_CELLS = ffba_pkg::POOL_CELLS_DEF,
	parameter int ID_BITS    = ffba_pkg::ID_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	ffba_req_if.sink   req,
	ffba_rsp_if.source rsp
);
	import ffba_pkg::*;

	localparam int IW = $clog2(POOL_CELLS);       // cell index width
	localparam int LW = $clog2(POOL_CELLS + 1);   // length / run width
	localparam logic [IW-1:0] LAST_CELL = IW'(POOL_CELLS - 1);

	// Controller states
	localparam logic [3:0] S_INIT = 4'd0;   // reset sweep of the owner map
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_SCAN = 4'd2;   // first-fit search, one cell per cycle
	localparam logic [3:0] S_FILL = 4'd3;   // stamp the found run with the new id
	localparam logic [3:0] S_FRDA = 4'd4;   // read the cell at position
	localparam logic [3:0] S_FRDB = 4'd5;   // check it, read the cell before (at cell 0: clear it, read the next)
	localparam logic [3:0] S_FRDC = 4'd6;   // check start of block
	localparam logic [3:0] S_FCLR = 4'd7;   // clear the run, one cell per cycle
	localparam logic [3:0] S_DONE = 4'd8;   // hand result to the output register

	logic [3:0]          state_q;
	logic [IW-1:0]       init_q;
	logic [IW-1:0]       rd_q;
	logic [IW-1:0]       idx_s1;
	logic                pend_s1;
	logic [LW-1:0]       run_q;
	logic [LW-1:0]       len_q;
	logic [IW-1:0]       start_q;
	logic [IW-1:0]       fill_q;
	logic [IW-1:0]       end_q;
	logic [IW-1:0]       pos_q;
	logic [IW-1:0]       cur_q;
	logic [ID_BITS-1:0]  id_q;
	logic [ID_BITS-1:0]  next_id_q;

	logic [STATUS_W-1:0] res_status_q;
	logic [START_W-1:0]  res_start_q;
	logic [OUT_ID_W-1:0] res_id_q;

	logic                out_vld_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [START_W-1:0]  out_start_q;
	logic [OUT_ID_W-1:0] out_id_q;

	// Owner-map RAM ports
	logic                ram_we;
	logic [IW-1:0]       ram_waddr;
	logic [ID_BITS-1:0]  ram_wdata;
	logic [IW-1:0]       ram_raddr;
	logic [ID_BITS-1:0]  ram_rdata;

	ffba_ram #(
		.WIDTH (ID_BITS),
		.DEPTH (POOL_CELLS)
	) u_owner_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Request decode
	logic              req_xfer;
	logic [PROD_W-1:0] req_len;
	logic              len_bad;
	logic              pos_out;

	assign req.ready = (state_q == S_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign req_len   = PROD_W'(req.element_count) * PROD_W'(req.element_size);
	assign len_bad   = (req_len == '0) || (32'(req_len) > 32'(POOL_CELLS));
	assign pos_out   = 32'(req.position) >= 32'(POOL_CELLS);

	// Scan datapath: run of free cells ending at the cell whose data just arrived
	logic [LW-1:0] run_n;
	logic          hit;
	logic          scan_last;
	logic [IW-1:0] hit_start;

	assign run_n     = (ram_rdata == '0) ? run_q + LW'(1) : '0;
	assign hit       = pend_s1 && (run_n == len_q);
	assign scan_last = pend_s1 && (idx_s1 == LAST_CELL);
	assign hit_start = IW'(LW'(idx_s1) + LW'(1) - len_q);

	// Wrap skips zero so that an owned cell never reads as free
	logic [ID_BITS-1:0] id_after;
	assign id_after = (next_id_q == '1) ? ID_BITS'(1) : next_id_q + ID_BITS'(1);

	logic out_load;
	assign out_load = (state_q == S_DONE) && (!out_vld_q || rsp.ready);

	// RAM port steering; free states write a cell and read the next in the same cycle
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = init_q;
		ram_wdata = '0;
		ram_raddr = rd_q;
		unique case (state_q)
			S_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = init_q;
			end
			S_SCAN: begin
				ram_raddr = rd_q;
			end
			S_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = fill_q;
				ram_wdata = next_id_q;
			end
			S_FRDA: begin
				ram_raddr = pos_q;
			end
			S_FRDB: begin
				if (ram_rdata != '0 && pos_q == '0) begin
					ram_we    = 1'b1;
					ram_waddr = pos_q;
					ram_raddr = pos_q + IW'(1);
				end else begin
					ram_raddr = pos_q - IW'(1);
				end
			end
			S_FRDC: begin
				ram_we    = (ram_rdata != id_q);
				ram_waddr = pos_q;
				ram_raddr = pos_q + IW'(1);
			end
			S_FCLR: begin
				ram_we    = (ram_rdata == id_q);
				ram_waddr = cur_q;
				ram_raddr = cur_q + IW'(1);
			end
			default: begin
			end
		endcase
	end

	// Controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			init_q       <= '0;
			rd_q         <= '0;
			idx_s1       <= '0;
			pend_s1      <= 1'b0;
			run_q        <= '0;
			len_q        <= '0;
			start_q      <= '0;
			fill_q       <= '0;
			end_q        <= '0;
			pos_q        <= '0;
			cur_q        <= '0;
			id_q         <= '0;
			next_id_q    <= ID_BITS'(1);
			res_status_q <= ST_OK;
			res_start_q  <= '0;
			res_id_q     <= '0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					init_q <= init_q + IW'(1);
					if (init_q == LAST_CELL) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					res_start_q <= '0;
					res_id_q    <= '0;
					if (req_xfer) begin
						if (req.mode == MODE_ALLOC) begin
							if (len_bad) begin
								res_status_q <= ST_NO_SPACE;
								state_q      <= S_DONE;
							end else begin
								len_q   <= LW'(req_len);
								rd_q    <= '0;
								pend_s1 <= 1'b0;
								run_q   <= '0;
								state_q <= S_SCAN;
							end
						end else if (!req.pointer_valid) begin
							res_status_q <= ST_NULL_PTR;
							state_q      <= S_DONE;
						end else if (pos_out) begin
							res_status_q <= ST_ALREADY_FREE;
							state_q      <= S_DONE;
						end else begin
							pos_q   <= IW'(req.position);
							state_q <= S_FRDA;
						end
					end
				end
				S_SCAN: begin
					// read issue runs one cell ahead of the data check
					rd_q    <= rd_q + IW'(1);
					idx_s1  <= rd_q;
					pend_s1 <= 1'b1;
					if (pend_s1) begin
						run_q <= run_n;
					end
					if (hit) begin
						start_q <= hit_start;
						fill_q  <= hit_start;
						end_q   <= idx_s1;
						state_q <= S_FILL;
					end else if (scan_last) begin
						res_status_q <= ST_NO_SPACE;
						state_q      <= S_DONE;
					end
				end
				S_FILL: begin
					fill_q <= fill_q + IW'(1);
					if (fill_q == end_q) begin
						res_status_q <= ST_OK;
						res_start_q  <= START_W'(start_q);
						res_id_q     <= OUT_ID_W'(next_id_q);
						next_id_q    <= id_after;
						state_q      <= S_DONE;
					end
				end
				S_FRDA: begin
					state_q <= S_FRDB;
				end
				S_FRDB: begin
					id_q <= ram_rdata;
					if (ram_rdata == '0) begin
						res_status_q <= ST_ALREADY_FREE;
						state_q      <= S_DONE;
					end else if (pos_q != '0) begin
						state_q <= S_FRDC;
					end else if (pos_q == LAST_CELL) begin
						res_status_q <= ST_OK;
						res_id_q     <= OUT_ID_W'(ram_rdata);
						state_q      <= S_DONE;
					end else begin
						cur_q   <= pos_q + IW'(1);
						state_q <= S_FCLR;
					end
				end
				S_FRDC: begin
					if (ram_rdata == id_q) begin
						res_status_q <= ST_NOT_START;
						state_q      <= S_DONE;
					end else if (pos_q == LAST_CELL) begin
						res_status_q <= ST_OK;
						res_id_q     <= OUT_ID_W'(id_q);
						state_q      <= S_DONE;
					end else begin
						cur_q   <= pos_q + IW'(1);
						state_q <= S_FCLR;
					end
				end
				S_FCLR: begin
					if (ram_rdata == id_q && cur_q != LAST_CELL) begin
						cur_q <= cur_q + IW'(1);
					end else begin
						res_status_q <= ST_OK;
						res_id_q     <= OUT_ID_W'(id_q);
						state_q      <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q    <= 1'b0;
			out_status_q <= ST_OK;
			out_start_q  <= '0;
			out_id_q     <= '0;
		end else if (out_load) begin
			out_vld_q    <= 1'b1;
			out_status_q <= res_status_q;
			out_start_q  <= res_start_q;
			out_id_q     <= res_id_q;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.status      = out_status_q;
	assign rsp.block_start = out_start_q;
	assign rsp.block_id    = out_id_q;

`ifndef SYNTH
	// id zero marks a free cell, so the counter must never reach it
	a_next_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_id_q != '0)
		else $error("next id reached zero");

	// fill walks forward from the run start and stops at the run end
	a_fill_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FILL |-> (fill_q >= start_q) && (fill_q <= end_q))
		else $error("fill address outside found run");

	// a failed request carries no start and no id
	a_fail_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_status_q != ST_OK |-> out_start_q == '0 && out_id_q == '0)
		else $error("failed result with nonzero payload");

	// owner map only receives data during sweep, fill or clear
	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_INIT || state_q == S_FILL || state_q == S_FRDB ||
			state_q == S_FRDC || state_q == S_FCLR))
		else $error("owner map written in wrong state");

	// a cell stamped in fill gets the id handed out on completion
	a_id_advance: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FILL && fill_q == end_q |=> res_id_q == OUT_ID_W'($past(next_id_q)))
		else $error("allocated id mismatch");
`endif

endmodule
